### rtl/lhp_pkg.sv
// Shared types, constants and filter functions for the luma half-pel interpolator.
`timescale 1ns / 1ps

package lhp_pkg;

  localparam int PixW     = 8;
  localparam int ColW     = 15;
  localparam int RowW     = 21;
  localparam int WinDepth = 5;
  localparam int FillW    = 3;

  localparam int ColRound = 16;
  localparam int ColShift = 5;
  localparam int RowRound = 512;
  localparam int RowShift = 10;

  localparam logic [0:0] ModeVert = 1'b0;
  localparam logic [0:0] ModeDiag = 1'b1;

  typedef logic [PixW-1:0]        pix_t;
  typedef logic signed [ColW-1:0] col_t;
  typedef logic signed [RowW-1:0] row_t;
  typedef logic [FillW-1:0]       fill_t;

  typedef struct packed {
    col_t col;
    logic row_start;
    logic row_end;
  } col_item_t;

  typedef struct packed {
    logic  take;
    fill_t fill;
  } win_stat_t;

  function automatic col_t tap_col(pix_t m2, pix_t m1, pix_t c0, pix_t c1, pix_t c2,
                                   pix_t c3);
    col_t a;
    col_t b;
    col_t c;
    a = ColW'(c0) + ColW'(c1);
    b = ColW'(m1) + ColW'(c2);
    c = ColW'(m2) + ColW'(c3);
    return (a <<< 4) + (a <<< 2) - (b <<< 2) - b + c;
  endfunction

  function automatic row_t tap_row(col_t m2, col_t m1, col_t c0, col_t c1, col_t c2,
                                   col_t c3);
    row_t a;
    row_t b;
    row_t c;
    a = RowW'(c0) + RowW'(c1);
    b = RowW'(m1) + RowW'(c2);
    c = RowW'(m2) + RowW'(c3);
    return (a <<< 4) + (a <<< 2) - (b <<< 2) - b + c;
  endfunction

  function automatic pix_t clip_col(col_t v);
    logic signed [ColW:0] t;
    logic [ColW-ColShift-1:0] r;
    t = (ColW+1)'(v) + (ColW+1)'(ColRound);
    r = t[ColW-1:ColShift];
    if (t[ColW]) begin
      return '0;
    end else if (|r[ColW-ColShift-1:PixW]) begin
      return '1;
    end else begin
      return r[PixW-1:0];
    end
  endfunction

  function automatic pix_t clip_row(row_t v);
    logic signed [RowW:0] t;
    logic [RowW-RowShift-1:0] r;
    t = (RowW+1)'(v) + (RowW+1)'(RowRound);
    r = t[RowW-1:RowShift];
    if (t[RowW]) begin
      return '0;
    end else if (|r[RowW-RowShift-1:PixW]) begin
      return '1;
    end else begin
      return r[PixW-1:0];
    end
  endfunction

endpackage

### rtl/lhp_col_stage.sv
// Input register and vertical six-tap column sum.
`timescale 1ns / 1ps

module lhp_col_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lhp_pkg::pix_t     in_pix_above2,
  input  lhp_pkg::pix_t     in_pix_above1,
  input  lhp_pkg::pix_t     in_pix_center,
  input  lhp_pkg::pix_t     in_pix_below1,
  input  lhp_pkg::pix_t     in_pix_below2,
  input  lhp_pkg::pix_t     in_pix_below3,
  input  logic              in_row_start,
  input  logic              in_row_end,
  input  logic              take,
  output logic              item_valid,
  output lhp_pkg::col_item_t item
);
  import lhp_pkg::*;

  logic valid_r;
  pix_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic start_r, end_r;
  logic load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p0_r    <= in_pix_above2;
      p1_r    <= in_pix_above1;
      p2_r    <= in_pix_center;
      p3_r    <= in_pix_below1;
      p4_r    <= in_pix_below2;
      p5_r    <= in_pix_below3;
      start_r <= in_row_start;
      end_r   <= in_row_end;
    end
  end

  assign item_valid     = valid_r;
  assign item.col       = tap_col(p0_r, p1_r, p2_r, p3_r, p4_r, p5_r);
  assign item.row_start = start_r;
  assign item.row_end   = end_r;

endmodule

### rtl/lhp_win_stage.sv
// Column-sum window, horizontal six-tap, rounding and result register.
`timescale 1ns / 1ps

module lhp_win_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               filter_mode,
  input  logic               item_valid,
  input  lhp_pkg::col_item_t item,
  output lhp_pkg::win_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output lhp_pkg::pix_t      out_sample,
  output logic               out_row_last
);
  import lhp_pkg::*;

  col_t  win_r [WinDepth];
  fill_t fill_r, fill_nxt, fill_eff;
  logic  out_valid_r, out_valid_nxt;
  pix_t  sample_r, sample_nxt;
  logic  last_r;
  logic  take, emit;

  assign take     = item_valid && (!out_valid_r || out_ready);
  assign fill_eff = item.row_start ? '0 : fill_r;
  assign emit     = (filter_mode == ModeVert) || (fill_eff >= FillW'(WinDepth));

  always_comb begin
    fill_nxt = fill_eff;
    if (fill_eff < FillW'(WinDepth)) begin
      fill_nxt = fill_eff + 1'b1;
    end
    if (filter_mode == ModeVert) begin
      sample_nxt = clip_col(item.col);
    end else begin
      sample_nxt = clip_row(tap_row(win_r[0], win_r[1], win_r[2], win_r[3], win_r[4],
                                    item.col));
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WinDepth-1] <= item.col;
      if (emit) begin
        sample_r <= sample_nxt;
        last_r   <= item.row_end;
      end
    end
  end

  assign stat.take    = take;
  assign stat.fill    = fill_r;
  assign out_valid    = out_valid_r;
  assign out_sample   = sample_r;
  assign out_row_last = last_r;

endmodule

### rtl/luma_halfpel_six_tap_interp_top.sv
// Top level of the H.264 luma six-tap half-pel interpolator.
// Each input item is one column of six luma pixels, rows -2..+3 around the
// output row, with row start and row end flags. Results leave on the out_
// channel as one clipped 8-bit sample plus a row-last flag.
// cfg_wr_en writes filter_mode: 0 vertical, 1 diagonal (center half-pel).
// Write it only while no item is in flight.
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle unless the receiver stalls; the column
// sum sits behind the input register and the horizontal tap, rounding
// and clip in front of the result register, so nothing iterates.
// Vertical mode gives one result per item. Diagonal mode gives none for
// the first five columns of a row and one per column after that.
// Reset clears the valid flags, the window fill count and filter_mode.
// A stalled receiver holds the result register; the input register takes
// an item only while it is empty or the next stage can move, so in_ready
// drops one item later.
`timescale 1ns / 1ps

module luma_halfpel_six_tap_interp_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  lhp_pkg::pix_t in_pix_above2,
  input  lhp_pkg::pix_t in_pix_above1,
  input  lhp_pkg::pix_t in_pix_center,
  input  lhp_pkg::pix_t in_pix_below1,
  input  lhp_pkg::pix_t in_pix_below2,
  input  lhp_pkg::pix_t in_pix_below3,
  input  logic          in_row_start,
  input  logic          in_row_end,
  output logic          out_valid,
  input  logic          out_ready,
  output lhp_pkg::pix_t out_sample,
  output logic          out_row_last
);
  import lhp_pkg::*;

  logic      filter_mode_r;
  logic      item_valid;
  col_item_t item;
  win_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= ModeVert;
    end else if (cfg_wr_en) begin
      filter_mode_r <= cfg_wr_data;
    end
  end

  lhp_col_stage u_col (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pix_above2 (in_pix_above2),
    .in_pix_above1 (in_pix_above1),
    .in_pix_center (in_pix_center),
    .in_pix_below1 (in_pix_below1),
    .in_pix_below2 (in_pix_below2),
    .in_pix_below3 (in_pix_below3),
    .in_row_start  (in_row_start),
    .in_row_end    (in_row_end),
    .take          (stat.take),
    .item_valid    (item_valid),
    .item          (item)
  );

  lhp_win_stage u_win (
    .clk          (clk),
    .rst_n        (rst_n),
    .filter_mode  (filter_mode_r),
    .item_valid   (item_valid),
    .item         (item),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_row_last (out_row_last)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= FillW'(WinDepth))
    else $error("window fill count beyond depth");

  a_vert_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.take && filter_mode_r == ModeVert) |=> out_valid)
    else $error("vertical item gave no result");

  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> item_valid)
    else $error("accepted item not held in input register");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !item_valid && stat.fill == '0))
    else $error("pipeline not idle after reset");

endmodule
